// ===== rtl/core/pcmx_pkg.sv =====
// Shared types, register indexes, format codes and saturation helpers for the
// PCM decode and crossfade mixer. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package pcmx_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_FORMAT     = 3'd0;
  localparam logic [2:0] REG_FEATHER_EN = 3'd1;
  localparam logic [2:0] REG_LENGTH     = 3'd2;
  localparam logic [2:0] REG_START_GAIN = 3'd3;
  localparam logic [2:0] REG_SLOPE      = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  // Sample format codes; the unused code decodes as 24-bit.
  localparam logic [1:0] FMT_8  = 2'd0;
  localparam logic [1:0] FMT_16 = 2'd1;
  localparam logic [1:0] FMT_24 = 2'd2;

  // Divisors of the narrow formats and their rounding offsets.
  localparam logic [15:0] DIV8   = 16'd127;
  localparam logic [15:0] DIV16  = 16'd32767;
  localparam logic [29:0] HALF8  = 30'd63;
  localparam logic [29:0] HALF16 = 30'd16383;

  // Reciprocals floor(2^RECIP_SHIFT / divisor) for the divide by a constant.
  localparam int          RECIP_SHIFT = 30;
  localparam logic [31:0] RECIP8      = 32'((64'd1 << RECIP_SHIFT) / 64'd127);
  localparam logic [31:0] RECIP16     = 32'((64'd1 << RECIP_SHIFT) / 64'd32767);

  // Width of the shared multiplier operands.
  localparam int MUL_W = 32;

  localparam logic signed [23:0] OUT_MAX = 24'sh7fffff;
  localparam logic signed [23:0] OUT_MIN = 24'sh800000;

  typedef struct packed {
    logic [1:0]  fmt;
    logic        feather_en;
    logic [15:0] length;
    logic [24:0] start_gain;
    logic [25:0] slope;
  } cfg_t;

  // Applies a sign to a magnitude and saturates to 24 bits signed.
  function automatic logic signed [23:0] sat_mag(input logic neg, input logic [33:0] mag);
    logic signed [23:0] result;
    if (neg) begin
      if (mag > 34'd8388608) result = OUT_MIN;
      else                   result = 24'(~mag + 34'd1);
    end else begin
      if (mag > 34'd8388607) result = OUT_MAX;
      else                   result = 24'(mag);
    end
    return result;
  endfunction

  // Saturates a 26-bit signed sum to 24 bits signed.
  function automatic logic signed [23:0] sat26(input logic signed [25:0] v);
    logic signed [23:0] result;
    if (v > 26'sd8388607)       result = OUT_MAX;
    else if (v < -26'sd8388608) result = OUT_MIN;
    else                        result = v[23:0];
    return result;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pcmx_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on pcmx_pkg for the operand width.
`timescale 1ns / 1ps
`default_nettype none

module pcmx_mul (
  input  wire logic                          clk,
  input  wire logic [pcmx_pkg::MUL_W-1:0]    a,
  input  wire logic [pcmx_pkg::MUL_W-1:0]    b,
  output logic      [2*pcmx_pkg::MUL_W-1:0]  p
);
  import pcmx_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcmx_cfg.sv =====
// Configuration register file of the mixer; writes are always accepted.
// Depends on pcmx_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module pcmx_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [pcmx_pkg::CFG_IDX_W-1:0]    wr_index,
  input  wire logic [pcmx_pkg::CFG_DATA_W-1:0]   wr_data,
  output pcmx_pkg::cfg_t                         cfg
);
  import pcmx_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt        <= FMT_16;
      cfg.feather_en <= 1'b0;
      cfg.length     <= '0;
      cfg.start_gain <= '0;
      cfg.slope      <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_FORMAT:     cfg.fmt        <= wr_data[1:0];
        REG_FEATHER_EN: cfg.feather_en <= wr_data[0];
        REG_LENGTH:     cfg.length     <= wr_data[15:0];
        REG_START_GAIN: cfg.start_gain <= wr_data[24:0];
        REG_SLOPE:      cfg.slope      <= wr_data[25:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcm_decode_crossfade_mixer.sv =====
// Top level of the PCM decode and crossfade mixer: sequencer and datapath.
// Depends on pcmx_pkg, pcmx_cfg (register file) and pcmx_mul (shared multiplier).
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction carries one raw PCM sample, the old mix sample at the
// same position and a last-in-buffer flag, and produces exactly one output
// transaction with the mixed Q1.23 sample. The block works on one sample at a
// time: in_stall is high from the cycle after a sample is taken until its
// result has moved into the output register. All products go through one
// shared 32x32 multiplier, so the sample period is set by how many products a
// sample needs. An 8-bit or 16-bit sample passes the decode steps DEC_Q, DEC_R,
// DEC_M and DEC_FIX; one in the added region past the crossfade adds CENTER, and
// a crossfaded one adds GAIN_MUL, GAIN_FIX, MIX_MUL and MIX_FIX. A 24-bit sample
// needs no decode products and skips to DEC_FIX; the output side can stall a
// finished result. The output register lets a new sample be taken while the
// previous result still waits. Configuration writes are accepted on every
// cycle and should only be issued while no sample is in flight.
module pcm_decode_crossfade_mixer #(
  parameter int FRACTION_BITS = 23,
  parameter int GAIN_BITS     = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Sample input channel.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [23:0]                raw_sample,
  input  wire logic signed [23:0]                old_mix,
  input  wire logic                              last_in_buffer,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [23:0]                     mixed_sample,
  // Configuration write channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pcmx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pcmx_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pcmx_pkg::*;

  // Split 2^FRACTION_BITS = Q * D + R so that the narrow decode becomes
  // |s| * Q plus a small division of |s| * R + D/2 by the constant D.
  localparam logic [63:0] POW_F = 64'd1 << FRACTION_BITS;
  localparam logic [31:0] Q8    = 32'(POW_F / 64'd127);
  localparam logic [15:0] R8    = 16'(POW_F % 64'd127);
  localparam logic [31:0] Q16   = 32'(POW_F / 64'd32767);
  localparam logic [15:0] R16   = 16'(POW_F % 64'd32767);

  // The 24-bit decode is a shift by FRACTION_BITS - 23 with rounding.
  localparam int WIDE_W = 25 + FRACTION_BITS;

  // Gain of one and the rounding offset of the crossfade product.
  localparam int          GAIN_W = GAIN_BITS + 1;
  localparam logic [42:0] GAIN_ONE = 43'(64'd1 << GAIN_BITS);
  localparam logic [63:0] HALF_G   = 64'd1 << (GAIN_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC_Q,
    S_DEC_R,
    S_DEC_M,
    S_DEC_FIX,
    S_CENTER,
    S_GAIN_MUL,
    S_GAIN_FIX,
    S_MIX_MUL,
    S_MIX_FIX,
    S_DONE
  } state_t;

  state_t state;

  cfg_t cfg;

  logic                 in_accept;
  logic                 out_load;

  // Per-sample registers.
  logic [15:0]          pos;
  logic [15:0]          k_reg;
  logic [23:0]          raw_reg;
  logic signed [23:0]   old_reg;
  logic [31:0]          base;
  logic [29:0]          x_reg;
  logic signed [23:0]   d_reg;
  logic [24:0]          diff_mag;
  logic                 diff_neg;
  logic [GAIN_W-1:0]    g_reg;
  logic signed [23:0]   res;

  // Shared multiplier.
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [2*MUL_W-1:0]   prod;

  // Decode datapath.
  logic [23:0]          s_val;
  logic                 s_neg;
  logic [23:0]          s_mag;
  logic                 is_wide;
  logic                 is_8;
  logic [31:0]          div_q;
  logic [15:0]          div_r;
  logic [29:0]          div_half;
  logic [31:0]          div_m;
  logic [15:0]          div_d;
  logic [29:0]          x_next;
  logic [23:0]          q0;
  logic [39:0]          q0_ext;
  logic [39:0]          q0_d;
  logic [39:0]          rem;
  logic [24:0]          q_frac;
  logic [33:0]          narrow_mag;
  logic [WIDE_W-1:0]    wide_sum;
  logic [33:0]          wide_mag;
  logic signed [23:0]   d_next;

  // Mixing datapath.
  logic signed [25:0]   center_sum;
  logic                 slope_neg;
  logic [25:0]          slope_mag;
  logic signed [42:0]   gain_term;
  logic signed [42:0]   gain_sum;
  logic [GAIN_W-1:0]    g_next;
  logic signed [24:0]   diff;
  logic [24:0]          diff_mag_next;
  logic [24:0]          mix_t;
  logic signed [25:0]   mix_term;
  logic signed [25:0]   mix_sum;

  pcmx_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pcmx_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  // Sign-extend the raw code per format and take its magnitude.
  always_comb begin
    unique case (cfg.fmt)
      FMT_8:   s_val = {{16{raw_reg[7]}}, raw_reg[7:0]};
      FMT_16:  s_val = {{8{raw_reg[15]}}, raw_reg[15:0]};
      default: s_val = raw_reg;
    endcase
  end

  assign s_neg   = s_val[23];
  assign s_mag   = s_neg ? (~s_val + 24'd1) : s_val;
  assign is_8    = (cfg.fmt == FMT_8);
  assign is_wide = (cfg.fmt != FMT_8) && (cfg.fmt != FMT_16);

  assign div_q    = is_8 ? Q8 : Q16;
  assign div_r    = is_8 ? R8 : R16;
  assign div_half = is_8 ? HALF8 : HALF16;
  assign div_m    = is_8 ? RECIP8 : RECIP16;
  assign div_d    = is_8 ? DIV8 : DIV16;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DEC_Q: begin
        mul_a = MUL_W'(s_mag);
        mul_b = div_q;
      end
      S_DEC_R: begin
        mul_a = MUL_W'(s_mag);
        mul_b = MUL_W'(div_r);
      end
      S_DEC_M: begin
        mul_a = MUL_W'(x_next);
        mul_b = div_m;
      end
      S_GAIN_MUL: begin
        mul_a = MUL_W'(slope_mag);
        mul_b = MUL_W'(k_reg);
      end
      S_MIX_MUL: begin
        mul_a = MUL_W'(diff_mag);
        mul_b = MUL_W'(g_reg);
      end
      default: ;
    endcase
  end

  // The remainder term |s| * R + D/2 stays below 2^30 for both narrow formats.
  assign x_next = prod[29:0] + div_half;

  // Reciprocal quotient is at most one short; one compare and add fixes it.
  assign q0     = prod[RECIP_SHIFT+23:RECIP_SHIFT];
  assign q0_ext = 40'(q0);
  assign q0_d   = is_8 ? ((q0_ext << 7) - q0_ext) : ((q0_ext << 15) - q0_ext);
  assign rem    = 40'(x_reg) - q0_d;
  assign q_frac = 25'(q0) + ((rem >= 40'(div_d)) ? 25'd1 : 25'd0);
  assign narrow_mag = 34'(base) + 34'(q_frac);

  // Wide format: round |s| * 2^FRACTION_BITS / 2^23 to nearest.
  assign wide_sum = (WIDE_W'(s_mag) << FRACTION_BITS) + (WIDE_W'(1) << 22);
  assign wide_mag = 34'(wide_sum >> 23);

  assign d_next = sat_mag(s_neg, is_wide ? wide_mag : narrow_mag);

  // Past the crossfade region the new sample is added into the old mix.
  assign center_sum = {{2{old_reg[23]}}, old_reg} + {{2{d_reg[23]}}, d_reg};

  // Gain = start + slope * k, clamped to [0, 1.0].
  assign slope_neg = cfg.slope[25];
  assign slope_mag = slope_neg ? (~cfg.slope + 26'd1) : cfg.slope;
  assign gain_term = slope_neg ? -$signed({2'b00, prod[40:0]}) : $signed({2'b00, prod[40:0]});
  assign gain_sum  = $signed({18'd0, cfg.start_gain}) + gain_term;

  always_comb begin
    if (gain_sum < 43'sd0)                  g_next = '0;
    else if ($unsigned(gain_sum) > GAIN_ONE) g_next = GAIN_W'(GAIN_ONE);
    else                                     g_next = GAIN_W'(gain_sum);
  end

  assign diff          = {d_reg[23], d_reg} - {old_reg[23], old_reg};
  assign diff_mag_next = diff[24] ? (~diff + 25'd1) : diff;

  // Crossfade: old + round((d - old) * g), ties away from zero.
  assign mix_t    = 25'((prod + HALF_G) >> GAIN_BITS);
  assign mix_term = diff_neg ? -$signed({1'b0, mix_t}) : $signed({1'b0, mix_t});
  assign mix_sum  = {{2{old_reg[23]}}, old_reg} + mix_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid    <= 1'b1;
        mixed_sample <= res;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            raw_reg <= raw_sample;
            old_reg <= old_mix;
            k_reg   <= pos;
            if (last_in_buffer)      pos <= '0;
            else if (pos != 16'hffff) pos <= pos + 16'd1;
            state <= is_wide ? S_DEC_FIX : S_DEC_Q;
          end
        end
        S_DEC_Q: state <= S_DEC_R;
        S_DEC_R: begin
          base  <= prod[31:0];
          state <= S_DEC_M;
        end
        S_DEC_M: begin
          x_reg <= x_next;
          state <= S_DEC_FIX;
        end
        S_DEC_FIX: begin
          d_reg <= d_next;
          res   <= d_next;
          if (!cfg.feather_en)          state <= S_DONE;
          else if (k_reg < cfg.length)  state <= S_GAIN_MUL;
          else                          state <= S_CENTER;
        end
        S_CENTER: begin
          res   <= sat26(center_sum);
          state <= S_DONE;
        end
        S_GAIN_MUL: state <= S_GAIN_FIX;
        S_GAIN_FIX: begin
          g_reg    <= g_next;
          diff_mag <= diff_mag_next;
          diff_neg <= diff[24];
          state    <= S_MIX_MUL;
        end
        S_MIX_MUL: state <= S_MIX_FIX;
        S_MIX_FIX: begin
          res   <= sat26(mix_sum);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A sample taken closes the input until its result is out.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("input not stalled after a transaction was taken");

  // A new result appears only from the final step of the sequencer.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result presented without finishing a sample");

  // The position counter advances by one on an ordinary sample.
  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !last_in_buffer && pos != 16'hffff) |=> (pos == $past(pos) + 16'd1))
    else $error("position counter did not advance");

endmodule

`default_nettype wire
